@@ sv/spl_pkg.sv @@
// Shared types and constants for the sump pump level controller.
package spl_pkg;

   // Sensor qualification window length in samples
   localparam int unsigned QUAL = 6;

   // Timer and register widths
   localparam int unsigned IDLE_W = 26;
   localparam int unsigned RUN_W  = 20;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = IDLE_W;

   // Timer saturation values
   localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
   localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};

   // Register reset values
   localparam logic [IDLE_W-1:0] INACT_LIMIT_RST = IDLE_W'(43200000);
   localparam logic [RUN_W-1:0]  RUN_LIMIT_RST   = RUN_W'(60000);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INACT_LIMIT = 2'd0,
      CSR_RUN_LIMIT   = 2'd1
   } csr_idx_type;

   // Event codes reported with each result
   typedef enum logic [2:0] {
      EV_NONE          = 3'd0,
      EV_START_FULL    = 3'd1,
      EV_START_IDLE    = 3'd2,
      EV_STOP_EMPTY    = 3'd3,
      EV_TMO_DISTRUST  = 3'd4,
      EV_TMO_FULL      = 3'd5,
      EV_TMO_OTHER     = 3'd6
   } event_type;

endpackage

@@ sv/sump_pump_level_controller_unit.sv @@
// Sump pump level controller: sensor qualification, start/stop control and event output.
// The result of each accepted request is registered in the output register.
// Throughput: one request per cycle; the controller state and the result are both
// updated in the accept cycle, so the only stall is a full, stalled output register.
// Reset (synchronous, active high): windows, timers and flags clear, limits return to
// their defaults (43200000 idle ticks, 60000 run ticks), and the output register empties.
module sump_pump_level_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_upper_raw,
   input  logic                                 req_lower_raw,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pump_on,
   output logic [2:0]                           rsp_event_res,
   output logic                                 rsp_fault_raised,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [spl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [spl_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import spl_pkg::*;

   // configuration registers
   logic [IDLE_W-1:0] inact_limit_ff;
   logic [RUN_W-1:0]  run_limit_ff;

   // controller state
   logic [QUAL-1:0]   upper_win_ff, upper_win_in;
   logic [QUAL-1:0]   lower_win_ff, lower_win_in;
   logic              pumping_ff, pumping_in;
   logic [RUN_W-1:0]  run_timer_ff, run_timer_in;
   logic [IDLE_W-1:0] idle_timer_ff, idle_timer_in;
   logic              has_run_ff, has_run_in;
   logic              distrust_ff, distrust_in;

   // output register
   logic              rsp_valid_ff;
   logic              pump_on_ff;
   event_type         event_ff, event_in;
   logic              fault_ff, fault_in;

   logic              req_accept;
   logic              full;
   logic              empty;
   logic              both;

   // accept whenever the output register is free or being drained
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inact_limit_ff <= INACT_LIMIT_RST;
         run_limit_ff   <= RUN_LIMIT_RST;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_INACT_LIMIT) begin
            inact_limit_ff <= csr_write_data[IDLE_W-1:0];
         end
         if (csr_index == CSR_RUN_LIMIT) begin
            run_limit_ff <= csr_write_data[RUN_W-1:0];
         end
      end
   end

   // sliding windows and qualified levels
   assign upper_win_in = {upper_win_ff[QUAL-2:0], req_upper_raw};
   assign lower_win_in = {lower_win_ff[QUAL-2:0], req_lower_raw};
   assign full  = ~(&upper_win_in);
   assign empty = &lower_win_in;
   assign both  = full & empty;

   // start / stop decision for one request
   always_comb begin
      pumping_in    = pumping_ff;
      run_timer_in  = run_timer_ff;
      idle_timer_in = idle_timer_ff;
      has_run_in    = has_run_ff;
      distrust_in   = distrust_ff;
      event_in      = EV_NONE;
      fault_in      = 1'b0;
      if (!pumping_ff) begin
         if (idle_timer_ff != IDLE_MAX) begin
            idle_timer_in = idle_timer_ff + 1'b1;
         end
         if (full) begin
            event_in = EV_START_FULL;
         end else if (!empty && has_run_ff && (idle_timer_in > inact_limit_ff)) begin
            event_in = EV_START_IDLE;
         end
         if (event_in != EV_NONE) begin
            fault_in     = both & ~distrust_ff;
            distrust_in  = both;
            pumping_in   = 1'b1;
            run_timer_in = '0;
         end
      end else begin
         if (run_timer_ff != RUN_MAX) begin
            run_timer_in = run_timer_ff + 1'b1;
         end
         if (run_timer_in > run_limit_ff) begin
            if (distrust_ff) begin
               event_in = EV_TMO_DISTRUST;
            end else if (full) begin
               event_in = EV_TMO_FULL;
            end else begin
               event_in = EV_TMO_OTHER;
            end
         end else if (empty && !distrust_ff) begin
            event_in = EV_STOP_EMPTY;
         end
         if (event_in != EV_NONE) begin
            pumping_in    = 1'b0;
            has_run_in    = 1'b1;
            idle_timer_in = '0;
         end
      end
   end

   // state update on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_win_ff  <= '0;
         lower_win_ff  <= '0;
         pumping_ff    <= 1'b0;
         run_timer_ff  <= '0;
         idle_timer_ff <= '0;
         has_run_ff    <= 1'b0;
         distrust_ff   <= 1'b0;
      end else if (req_accept) begin
         upper_win_ff  <= upper_win_in;
         lower_win_ff  <= lower_win_in;
         pumping_ff    <= pumping_in;
         run_timer_ff  <= run_timer_in;
         idle_timer_ff <= idle_timer_in;
         has_run_ff    <= has_run_in;
         distrust_ff   <= distrust_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pump_on_ff <= pumping_in;
         event_ff   <= event_in;
         fault_ff   <= fault_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pump_on      = pump_on_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_fault_raised = fault_ff;

   // checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request left no result");

   a_fault_on_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fault_ff) |-> (event_ff == EV_START_FULL))
      else $error("fault flagged without a full-tank start");

   a_start_drives: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (event_ff == EV_START_FULL || event_ff == EV_START_IDLE))
         |-> pump_on_ff)
      else $error("start event with pump off");

   a_stop_drives: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (event_ff == EV_STOP_EMPTY || event_ff == EV_TMO_DISTRUST ||
         event_ff == EV_TMO_FULL || event_ff == EV_TMO_OTHER)) |-> !pump_on_ff)
      else $error("stop event with pump on");

endmodule
